>>> design/rgb_to_hsl_converter_defines.svh
// Assertion macros for the RGB to HSL converter.
// Needs a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef RGB_TO_HSL_CONVERTER_DEFINES_SVH
`define RGB_TO_HSL_CONVERTER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RTH_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rgb_to_hsl_converter: implication check failed");

// Delayed implication; the delay is given by the argument n.
`define RTH_ASSERT_DELAY(label, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(n) (cons)) \
    else $error("rgb_to_hsl_converter: latency check failed");

`endif

>>> design/rth_pkg.sv
// Shared widths, constants and types of the RGB to HSL converter.
// No dependencies; used by rth_div and rgb_to_hsl_converter.
package rth_pkg;

  localparam int COMP_W  = 8;   // color component and alpha
  localparam int LIGHT_W = 9;   // max + min
  localparam int FRAC_W  = 16;  // hue and saturation fractions
  localparam int DIV_W   = 11;  // divider operands, up to 6 * 255
  localparam int QUOT_W  = FRAC_W + 1;  // one integer bit for full saturation

  localparam int DIV_STEPS_PER_STAGE = 4;

  localparam logic [LIGHT_W-1:0] SUM_HALF = 9'd255;
  localparam logic [LIGHT_W-1:0] SUM_FULL = 9'd510;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

endpackage

>>> design/rth_div.sv
// Pipelined restoring divider: floor(num * 2^16 / den) with one integer bit.
// Depends on rth_pkg. Requires num <= den; den of zero gives all ones.
module rth_div #(
  parameter int STEPS_PER_STAGE = rth_pkg::DIV_STEPS_PER_STAGE
) (
  input  logic                        clk,
  input  logic [rth_pkg::DIV_W-1:0]   in_num,
  input  logic [rth_pkg::DIV_W-1:0]   in_den,
  output logic [rth_pkg::QUOT_W-1:0]  out_quot
);

  localparam int DW     = rth_pkg::DIV_W;
  localparam int QW     = rth_pkg::QUOT_W;
  localparam int STAGES = (QW + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

  logic [DW-1:0] rem_r [STAGES];
  logic [DW-1:0] den_r [STAGES];
  logic [QW-1:0] quo_r [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [DW-1:0] rem_nxt;
    logic [QW-1:0] quo_nxt;

    if (s == 0) begin : g_first
      assign rem_in = in_num;
      assign den_in = in_den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign den_in = den_r[s-1];
      assign quo_in = quo_r[s-1];
    end

    always_comb begin : p_steps
      logic [DW:0]   acc;
      logic [QW-1:0] q;
      acc = {1'b0, rem_in};
      q   = quo_in;
      for (int j = 0; j < STEPS_PER_STAGE; j++) begin
        if (s * STEPS_PER_STAGE + j < QW) begin
          // the first step yields the integer bit, so skip its doubling
          if (s * STEPS_PER_STAGE + j != 0) begin
            acc = {acc[DW-1:0], 1'b0};
          end
          if (acc >= {1'b0, den_in}) begin
            acc = acc - {1'b0, den_in};
            q   = {q[QW-2:0], 1'b1};
          end else begin
            q   = {q[QW-2:0], 1'b0};
          end
        end
      end
      rem_nxt = acc[DW-1:0];
      quo_nxt = q;
    end

    always_ff @(posedge clk) begin
      rem_r[s] <= rem_nxt;
      den_r[s] <= den_in;
      quo_r[s] <= quo_nxt;
    end
  end

  assign out_quot = quo_r[STAGES-1];

endmodule

>>> design/rgb_to_hsl_converter.sv
// RGB to HSL converter, one pixel word per clock.
// Depends on rth_pkg, rth_div and rgb_to_hsl_converter_defines.svh.
//
// Input channel: a word (in_red, in_green, in_blue, in_alpha) is taken at a
// rising edge where start is high and busy is low. busy stays low, so a new
// word may be offered on every clock.
// Result channel: out_valid is high for one cycle while out_hue,
// out_saturation, out_lightness_doubled and out_alpha_out hold the word.
// The receiver has no hold-off; every result must be taken when shown.
// Path: stage A register, stage B register, the divider stages and the output
// register, in that order; the default is 4 divider steps per stage.
// Throughput: one word per cycle. The depth is set by the two 17-bit
// quotient dividers (hue and saturation), each retiring STEPS_PER_STAGE
// quotient bits per pipeline stage.
// Reset: a synchronous low on rst_n clears every valid bit in the pipeline;
// words in flight are dropped. The data registers are not reset.
// Lightness comes out as max + min (0..510). A gray pixel gives hue and
// saturation of zero; full saturation reads 65535.
`include "rgb_to_hsl_converter_defines.svh"

module rgb_to_hsl_converter #(
  parameter int STEPS_PER_STAGE = rth_pkg::DIV_STEPS_PER_STAGE
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [rth_pkg::COMP_W-1:0]   in_red,
  input  logic [rth_pkg::COMP_W-1:0]   in_green,
  input  logic [rth_pkg::COMP_W-1:0]   in_blue,
  input  logic [rth_pkg::COMP_W-1:0]   in_alpha,
  output logic                         out_valid,
  output logic [rth_pkg::FRAC_W-1:0]   out_hue,
  output logic [rth_pkg::FRAC_W-1:0]   out_saturation,
  output logic [rth_pkg::LIGHT_W-1:0]  out_lightness_doubled,
  output logic [rth_pkg::COMP_W-1:0]   out_alpha_out
);

  localparam int CW      = rth_pkg::COMP_W;
  localparam int LW      = rth_pkg::LIGHT_W;
  localparam int FW      = rth_pkg::FRAC_W;
  localparam int DW      = rth_pkg::DIV_W;
  localparam int QW      = rth_pkg::QUOT_W;
  localparam int STAGES  = (QW + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int LAT_CYC = STAGES + 3;

  typedef struct packed {
    logic          gray;
    logic [LW-1:0] sum;
    logic [CW-1:0] alpha;
  } side_t;

  // ---------------- stage A: max, min, winning channel
  logic [CW-1:0]    max_c, min_c;
  rth_pkg::sector_t sec_c;

  always_comb begin
    max_c = in_red;
    if (in_green > max_c) max_c = in_green;
    if (in_blue > max_c) max_c = in_blue;
    min_c = in_red;
    if (in_green < min_c) min_c = in_green;
    if (in_blue < min_c) min_c = in_blue;
    // ties go to red, then green
    if (max_c == in_red) begin
      sec_c = rth_pkg::SEC_RED;
    end else if (max_c == in_green) begin
      sec_c = rth_pkg::SEC_GREEN;
    end else begin
      sec_c = rth_pkg::SEC_BLUE;
    end
  end

  logic             v_a_r;
  logic [CW-1:0]    max_a_r, min_a_r, red_a_r, green_a_r, blue_a_r, alpha_a_r;
  rth_pkg::sector_t sec_a_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
    end else begin
      v_a_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    max_a_r   <= max_c;
    min_a_r   <= min_c;
    sec_a_r   <= sec_c;
    red_a_r   <= in_red;
    green_a_r <= in_green;
    blue_a_r  <= in_blue;
    alpha_a_r <= in_alpha;
  end

  // ---------------- stage B: divider operands
  logic [CW-1:0] d_c;
  logic [LW-1:0] sum_c;
  logic [LW-1:0] den_s_c;
  logic [DW-1:0] d6_c;
  logic [DW-1:0] num_h_c;

  always_comb begin
    d_c     = max_a_r - min_a_r;
    sum_c   = {1'b0, max_a_r} + {1'b0, min_a_r};
    den_s_c = (sum_c <= rth_pkg::SUM_HALF) ? sum_c : (rth_pkg::SUM_FULL - sum_c);
    d6_c    = {1'b0, d_c, 2'b00} + {2'b00, d_c, 1'b0};
    case (sec_a_r)
      rth_pkg::SEC_RED: begin
        if (green_a_r >= blue_a_r) begin
          num_h_c = {3'b000, green_a_r - blue_a_r};
        end else begin
          num_h_c = d6_c - {3'b000, blue_a_r - green_a_r};
        end
      end
      // 2d + b - r and 4d + r - g never go negative
      rth_pkg::SEC_GREEN: begin
        num_h_c = {2'b00, d_c, 1'b0} + {3'b000, blue_a_r} - {3'b000, red_a_r};
      end
      rth_pkg::SEC_BLUE: begin
        num_h_c = {1'b0, d_c, 2'b00} + {3'b000, red_a_r} - {3'b000, green_a_r};
      end
      default: begin
        num_h_c = '0;
      end
    endcase
  end

  logic          v_b_r;
  logic [DW-1:0] num_h_b_r, den_h_b_r, num_s_b_r, den_s_b_r;
  side_t         side_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_b_r <= 1'b0;
    end else begin
      v_b_r <= v_a_r;
    end
  end

  always_ff @(posedge clk) begin
    num_h_b_r      <= num_h_c;
    den_h_b_r      <= d6_c;
    num_s_b_r      <= {3'b000, d_c};
    den_s_b_r      <= {2'b00, den_s_c};
    side_b_r.gray  <= (d_c == '0);
    side_b_r.sum   <= sum_c;
    side_b_r.alpha <= alpha_a_r;
  end

  // ---------------- divider stages, side data travels alongside
  logic [QW-1:0] quot_h, quot_s;

  rth_div #(
    .STEPS_PER_STAGE (STEPS_PER_STAGE)
  ) u_div_hue (
    .clk      (clk),
    .in_num   (num_h_b_r),
    .in_den   (den_h_b_r),
    .out_quot (quot_h)
  );

  rth_div #(
    .STEPS_PER_STAGE (STEPS_PER_STAGE)
  ) u_div_sat (
    .clk      (clk),
    .in_num   (num_s_b_r),
    .in_den   (den_s_b_r),
    .out_quot (quot_s)
  );

  logic  v_p_r    [STAGES];
  side_t side_p_r [STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STAGES; i++) begin
        v_p_r[i] <= 1'b0;
      end
    end else begin
      v_p_r[0] <= v_b_r;
      for (int i = 1; i < STAGES; i++) begin
        v_p_r[i] <= v_p_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    side_p_r[0] <= side_b_r;
    for (int i = 1; i < STAGES; i++) begin
      side_p_r[i] <= side_p_r[i-1];
    end
  end

  // ---------------- output register
  logic          out_valid_r;
  logic [FW-1:0] hue_r, sat_r;
  logic [LW-1:0] light_r;
  logic [CW-1:0] alpha_r;
  side_t         side_last;

  assign side_last = side_p_r[STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v_p_r[STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    // drop the quotients of a gray pixel, clamp a quotient of one
    if (side_last.gray) begin
      hue_r <= '0;
      sat_r <= '0;
    end else begin
      hue_r <= quot_h[FW-1:0];
      sat_r <= quot_s[QW-1] ? {FW{1'b1}} : quot_s[FW-1:0];
    end
    light_r <= side_last.sum;
    alpha_r <= side_last.alpha;
  end

  assign out_valid             = out_valid_r;
  assign out_hue               = hue_r;
  assign out_saturation        = sat_r;
  assign out_lightness_doubled = light_r;
  assign out_alpha_out         = alpha_r;

  // ---------------- checks
  `RTH_ASSERT_DELAY(a_word_arrives, start && !busy, LAT_CYC, out_valid)
  `RTH_ASSERT_IMPLY(a_no_stray_word, out_valid, $past(start && !busy, LAT_CYC))
  `RTH_ASSERT_IMPLY(a_hue_needs_sat, out_valid && (out_hue != '0), out_saturation != '0)

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for rgb_to_hsl_converter: pixel words in, HSL words out.
// Depends on rth_pkg and the converter RTL. It predicts each result from the
// pixel and checks the results in order.
`timescale 1ns / 1ps

module tb;

  typedef struct {
    logic [rth_pkg::COMP_W-1:0] red;
    logic [rth_pkg::COMP_W-1:0] green;
    logic [rth_pkg::COMP_W-1:0] blue;
    logic [rth_pkg::COMP_W-1:0] alpha;
  } rgba_word_t;

  typedef struct {
    logic [rth_pkg::FRAC_W-1:0]  hue;
    logic [rth_pkg::FRAC_W-1:0]  saturation;
    logic [rth_pkg::LIGHT_W-1:0] lightness;
    logic [rth_pkg::COMP_W-1:0]  alpha;
  } hsl_word_t;

  localparam int PIXEL_COUNT = 400;
  localparam int IDLE_PCT    = 34;
  localparam int BURST_FIRST = 150;
  localparam int BURST_LAST  = 250;
  localparam int DRAIN_WAIT  = 20;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic [rth_pkg::COMP_W-1:0]  in_red = '0;
  logic [rth_pkg::COMP_W-1:0]  in_green = '0;
  logic [rth_pkg::COMP_W-1:0]  in_blue = '0;
  logic [rth_pkg::COMP_W-1:0]  in_alpha = '0;
  logic                        out_valid;
  logic [rth_pkg::FRAC_W-1:0]  out_hue;
  logic [rth_pkg::FRAC_W-1:0]  out_saturation;
  logic [rth_pkg::LIGHT_W-1:0] out_lightness_doubled;
  logic [rth_pkg::COMP_W-1:0]  out_alpha_out;

  rgba_word_t pixel_queue[$];
  hsl_word_t  hsl_due[$];
  int         accepted_count = 0;
  int         mismatch_count = 0;

  rgb_to_hsl_converter u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_red                (in_red),
    .in_green              (in_green),
    .in_blue               (in_blue),
    .in_alpha              (in_alpha),
    .out_valid             (out_valid),
    .out_hue               (out_hue),
    .out_saturation        (out_saturation),
    .out_lightness_doubled (out_lightness_doubled),
    .out_alpha_out         (out_alpha_out)
  );

  always #5 clk = ~clk;

  function automatic hsl_word_t hsl_of(rgba_word_t p);
    int unsigned      r, g, b, hi, lo, span, total, denom, numer, quot;
    rth_pkg::sector_t sec;
    hsl_word_t        w;
    r = 32'(p.red);
    g = 32'(p.green);
    b = 32'(p.blue);
    hi = r;
    lo = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    span = hi - lo;
    total = hi + lo;
    w.hue = '0;
    w.saturation = '0;
    w.lightness = total[rth_pkg::LIGHT_W-1:0];
    w.alpha = p.alpha;
    if (span != 0) begin
      denom = (total <= 32'(rth_pkg::SUM_HALF)) ? total : (32'(rth_pkg::SUM_FULL) - total);
      quot = (span * 65536) / denom;
      w.saturation = (quot > 65535) ? 16'hFFFF : quot[rth_pkg::FRAC_W-1:0];
      // ties for the maximum go to red, then green
      if (hi == r) sec = rth_pkg::SEC_RED;
      else if (hi == g) sec = rth_pkg::SEC_GREEN;
      else sec = rth_pkg::SEC_BLUE;
      case (sec)
        rth_pkg::SEC_RED: begin
          numer = (g >= b) ? (g - b) : (6 * span - (b - g));
        end
        rth_pkg::SEC_GREEN: begin
          numer = 2 * span + b - r;
        end
        default: begin
          numer = 4 * span + r - g;
        end
      endcase
      quot = (numer * 65536) / (6 * span);
      w.hue = quot[rth_pkg::FRAC_W-1:0];
    end
    return w;
  endfunction

  task automatic add_pixel(int r, int g, int b, int a);
    rgba_word_t p;
    p.red = r[rth_pkg::COMP_W-1:0];
    p.green = g[rth_pkg::COMP_W-1:0];
    p.blue = b[rth_pkg::COMP_W-1:0];
    p.alpha = a[rth_pkg::COMP_W-1:0];
    pixel_queue.push_back(p);
  endtask

  // Driver: record each accepted word, then offer the next one or idle.
  always @(posedge clk) begin
    rgba_word_t p;
    bit         burst;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        p.red = in_red;
        p.green = in_green;
        p.blue = in_blue;
        p.alpha = in_alpha;
        hsl_due.push_back(hsl_of(p));
        accepted_count++;
      end
      if (!start || !busy) begin
        burst = (accepted_count >= BURST_FIRST) && (accepted_count < BURST_LAST);
        if (pixel_queue.size() != 0 && (burst || $urandom_range(99) >= IDLE_PCT)) begin
          p = pixel_queue.pop_front();
          start    <= 1'b1;
          in_red   <= p.red;
          in_green <= p.green;
          in_blue  <= p.blue;
          in_alpha <= p.alpha;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed word must match the oldest prediction.
  always @(posedge clk) begin
    hsl_word_t w;
    if (rst_n && out_valid === 1'b1) begin
      if (hsl_due.size() == 0) begin
        $error("result word with no prediction pending");
        mismatch_count++;
      end else begin
        w = hsl_due.pop_front();
        if (out_hue !== w.hue) begin
          $error("hue: expected %0d, actual %0d", w.hue, out_hue);
          mismatch_count++;
        end
        if (out_saturation !== w.saturation) begin
          $error("saturation: expected %0d, actual %0d", w.saturation, out_saturation);
          mismatch_count++;
        end
        if (out_lightness_doubled !== w.lightness) begin
          $error("lightness_doubled: expected %0d, actual %0d", w.lightness,
                 out_lightness_doubled);
          mismatch_count++;
        end
        if (out_alpha_out !== w.alpha) begin
          $error("alpha_out: expected %0d, actual %0d", w.alpha, out_alpha_out);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int kind, r, g, b, lvl;
    // corners: black, white, grays, primaries, secondaries, hue wrap side
    add_pixel(0, 0, 0, 0);
    add_pixel(255, 255, 255, 255);
    add_pixel(128, 128, 128, 170);
    add_pixel(1, 1, 1, 85);
    add_pixel(255, 0, 0, 255);
    add_pixel(0, 255, 0, 0);
    add_pixel(0, 0, 255, 128);
    add_pixel(255, 255, 0, 1);
    add_pixel(0, 255, 255, 254);
    add_pixel(255, 0, 255, 127);
    add_pixel(200, 10, 11, 90);
    add_pixel(200, 11, 10, 91);
    add_pixel(100, 200, 50, 33);
    add_pixel(50, 100, 200, 66);
    add_pixel(255, 255, 254, 200);
    add_pixel(1, 0, 0, 17);
    add_pixel(0, 0, 1, 18);
    add_pixel(254, 255, 255, 19);
    add_pixel(128, 127, 127, 20);
    add_pixel(127, 128, 128, 21);
    add_pixel(170, 85, 85, 22);
    add_pixel(60, 60, 200, 23);
    for (int i = 0; i < PIXEL_COUNT; i++) begin
      kind = $urandom_range(9);
      r = $urandom_range(255);
      g = $urandom_range(255);
      b = $urandom_range(255);
      case (kind)
        0: begin
          g = r;
          b = r;
        end
        1: begin
          lvl = $urandom_range(2);
          if (lvl == 0) g = r;
          else if (lvl == 1) b = g;
          else b = r;
        end
        2: begin
          lvl = $urandom_range(1) ? 255 : 0;
          if ($urandom_range(2) == 0) r = lvl;
          else if ($urandom_range(1) == 0) g = lvl;
          else b = lvl;
        end
        default: ;
      endcase
      add_pixel(r, g, b, $urandom_range(255));
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    while (pixel_queue.size() != 0 || start || hsl_due.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (hsl_due.size() != 0) begin
      $error("%0d predicted words never arrived", hsl_due.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
